>>> hw/rtl/iss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed sequential search block.
// No dependencies; imported by every module of the block.
package iss_pkg;

   localparam int VALUE_W          = 32;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 11;
   localparam int POS_W            = 10;
   localparam int DEF_ARRAY_DEPTH  = 1024;
   localparam int DEF_INDEX_DEPTH  = 64;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [CSR_IDX_W-1:0]  CSR_USED_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_INDEX_STRIDE = 2'd1;
   localparam logic [CSR_DATA_W-1:0] RESET_USED_LENGTH  = 11'd1;
   localparam logic [CSR_DATA_W-1:0] RESET_INDEX_STRIDE = 11'd16;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic {
      OP_WRITE,
      OP_SEARCH
   } op_type;

   typedef struct packed {
      op_type op;
      logic   mark_index;
   } entry_ctrl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_IDX,
      S_SEG,
      S_DONE
   } search_state_type;

endpackage

>>> hw/rtl/iss_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, tracks load pointer and index bookkeeping,
// and issues write or search entries to the queue. Uses iss_pkg.
module iss_front import iss_pkg::*; #(
   parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
   parameter int INDEX_DEPTH = DEF_INDEX_DEPTH,
   localparam int LEN_W = $clog2(ARRAY_DEPTH + 1),
   localparam int AW    = $clog2(ARRAY_DEPTH),
   localparam int ICW   = $clog2(INDEX_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_command,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic [LEN_W-1:0]          eff_len,
   input  logic [LEN_W-1:0]          eff_stride,
   output logic                      push_valid,
   input  logic                      push_ready,
   output entry_ctrl_type            push_ctrl,
   output logic [AW-1:0]             push_addr,
   output logic [ICW-1:0]            push_slot,
   output logic [VALUE_W-1:0]        push_value
);

   logic [LEN_W-1:0] load_ptr_ff, load_ptr_in;
   logic [LEN_W-1:0] stride_cnt_ff, stride_cnt_in;
   logic [ICW-1:0]   index_cnt_ff, index_cnt_in;
   logic             searched_ff, searched_in;

   logic [LEN_W-1:0] base_ptr;
   logic [LEN_W-1:0] base_sc;
   logic [LEN_W-1:0] next_sc;
   logic [ICW-1:0]   base_ic;
   logic             in_range;
   logic             mark;
   logic             accept;
   logic             is_search;

   assign is_search = (req_command == CMD_SEARCH);
   assign base_ptr  = searched_ff ? '0 : load_ptr_ff;
   assign base_sc   = searched_ff ? '0 : stride_cnt_ff;
   assign base_ic   = searched_ff ? '0 : index_cnt_ff;
   assign in_range  = (base_ptr < eff_len);
   assign mark      = (base_sc == '0) && (base_ic < ICW'(INDEX_DEPTH));
   assign next_sc   = base_sc + LEN_W'(1);

   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;
   assign push_valid = req_valid && (is_search || in_range);

   assign push_ctrl.op         = is_search ? OP_SEARCH : OP_WRITE;
   assign push_ctrl.mark_index = mark;
   assign push_addr            = base_ptr[AW-1:0];
   assign push_slot            = is_search ? index_cnt_ff : base_ic;
   assign push_value           = req_item_value;

   always_comb begin
      load_ptr_in   = load_ptr_ff;
      stride_cnt_in = stride_cnt_ff;
      index_cnt_in  = index_cnt_ff;
      searched_in   = searched_ff;
      if (accept) begin
         if (is_search) begin
            searched_in = 1'b1;
         end else begin
            searched_in   = 1'b0;
            load_ptr_in   = base_ptr;
            stride_cnt_in = base_sc;
            index_cnt_in  = base_ic;
            if (in_range) begin
               load_ptr_in   = base_ptr + LEN_W'(1);
               stride_cnt_in = (next_sc >= eff_stride) ? '0 : next_sc;
               if (mark) begin
                  index_cnt_in = base_ic + ICW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff   <= '0;
         stride_cnt_ff <= '0;
         index_cnt_ff  <= '0;
         searched_ff   <= 1'b0;
      end else begin
         load_ptr_ff   <= load_ptr_in;
         stride_cnt_ff <= stride_cnt_in;
         index_cnt_ff  <= index_cnt_in;
         searched_ff   <= searched_in;
      end
   end

endmodule

>>> hw/rtl/iss_queue.sv
`timescale 1ns / 1ps
// Short FIFO between the front end and the search engine.
// Uses iss_pkg for the default depth.
module iss_queue import iss_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/iss_back.sv
`timescale 1ns / 1ps
// Search engine: owns the element and index memories, performs writes and
// runs the range check, index walk and segment scan. Uses iss_pkg.
module iss_back import iss_pkg::*; #(
   parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
   parameter int INDEX_DEPTH = DEF_INDEX_DEPTH,
   localparam int LEN_W = $clog2(ARRAY_DEPTH + 1),
   localparam int PW    = LEN_W + 1,
   localparam int AW    = $clog2(ARRAY_DEPTH),
   localparam int ICW   = $clog2(INDEX_DEPTH + 1),
   localparam int IW    = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [LEN_W-1:0]    eff_len,
   input  logic [LEN_W-1:0]    eff_stride,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  entry_ctrl_type      pop_ctrl,
   input  logic [AW-1:0]       pop_addr,
   input  logic [ICW-1:0]      pop_slot,
   input  logic [VALUE_W-1:0]  pop_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output logic                rsp_out_of_range,
   output logic [POS_W-1:0]    rsp_position,
   output logic [POS_W-1:0]    rsp_segment_start
);

   logic signed [VALUE_W-1:0] elem_mem_ff [ARRAY_DEPTH];
   logic signed [VALUE_W-1:0] idx_mem_ff [INDEX_DEPTH];
   logic signed [VALUE_W-1:0] elem_rdata_ff;
   logic signed [VALUE_W-1:0] idx_rdata_ff;
   logic                      elem_we, idx_we, elem_re, idx_re;
   logic [AW-1:0]             elem_raddr;
   logic [IW-1:0]             idx_raddr;

   search_state_type          state_ff, state_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [ICW-1:0]            cnt_ff, cnt_in;
   logic                      lt_ff, lt_in;
   logic [ICW-1:0]            k_ff, k_in;
   logic [PW-1:0]             kpos_ff, kpos_in;
   logic                      pend_ff, pend_in;
   logic [ICW-1:0]            rd_k_ff, rd_k_in;
   logic [LEN_W-1:0]          rd_pos_ff, rd_pos_in;
   logic                      have_ff, have_in;
   logic [ICW-1:0]            chosen_k_ff, chosen_k_in;
   logic [LEN_W-1:0]          chosen_pos_ff, chosen_pos_in;
   logic [LEN_W-1:0]          i_ff, i_in;
   logic [LEN_W-1:0]          end_ff, end_in;
   logic [LEN_W-1:0]          seg_ff, seg_in;
   logic                      res_found_ff, res_found_in;
   logic                      res_oor_ff, res_oor_in;
   logic [LEN_W-1:0]          res_pos_ff, res_pos_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_oor_ff;
   logic [LEN_W-1:0]          rsp_pos_ff, rsp_seg_ff;
   logic                      rsp_load;

   logic [LEN_W-1:0]          last_idx;
   logic                      issue_idx;
   logic [LEN_W:0]            next_entry_pos;
   logic                      next_entry_used;
   logic [LEN_W+POS_W-1:0]    pos_wide, seg_wide;

   assign last_idx        = eff_len - LEN_W'(1);
   assign issue_idx       = (k_ff < cnt_ff) && (kpos_ff < {1'b0, eff_len});
   assign next_entry_pos  = {1'b0, chosen_pos_ff} + {1'b0, eff_stride};
   assign next_entry_used = (({1'b0, chosen_k_ff} + (ICW + 1)'(1)) < {1'b0, cnt_ff})
                            && (next_entry_pos < {1'b0, eff_len});
   assign pop_ready       = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      lt_in         = lt_ff;
      k_in          = k_ff;
      kpos_in       = kpos_ff;
      pend_in       = pend_ff;
      rd_k_in       = rd_k_ff;
      rd_pos_in     = rd_pos_ff;
      have_in       = have_ff;
      chosen_k_in   = chosen_k_ff;
      chosen_pos_in = chosen_pos_ff;
      i_in          = i_ff;
      end_in        = end_ff;
      seg_in        = seg_ff;
      res_found_in  = res_found_ff;
      res_oor_in    = res_oor_ff;
      res_pos_in    = res_pos_ff;
      elem_we       = 1'b0;
      idx_we        = 1'b0;
      elem_re       = 1'b0;
      idx_re        = 1'b0;
      elem_raddr    = '0;
      idx_raddr     = k_ff[IW-1:0];
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               if (pop_ctrl.op == OP_WRITE) begin
                  elem_we = 1'b1;
                  idx_we  = pop_ctrl.mark_index;
               end else begin
                  key_in       = pop_value;
                  cnt_in       = pop_slot;
                  res_found_in = 1'b0;
                  res_oor_in   = 1'b0;
                  res_pos_in   = '0;
                  seg_in       = '0;
                  if (eff_len == '0) begin
                     res_oor_in = 1'b1;
                     state_in   = S_DONE;
                  end else begin
                     elem_re  = 1'b1;
                     state_in = S_FIRST;
                  end
               end
            end
         end
         S_FIRST: begin
            lt_in      = (key_ff < elem_rdata_ff);
            elem_re    = 1'b1;
            elem_raddr = last_idx[AW-1:0];
            state_in   = S_LAST;
         end
         S_LAST: begin
            if (lt_ff || (key_ff > elem_rdata_ff)) begin
               res_oor_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               k_in     = '0;
               kpos_in  = '0;
               pend_in  = 1'b0;
               have_in  = 1'b0;
               state_in = S_IDX;
            end
         end
         S_IDX: begin
            if (pend_ff && (idx_rdata_ff <= key_ff)) begin
               have_in       = 1'b1;
               chosen_k_in   = rd_k_ff;
               chosen_pos_in = rd_pos_ff;
            end
            if (issue_idx) begin
               idx_re    = 1'b1;
               rd_k_in   = k_ff;
               rd_pos_in = kpos_ff[LEN_W-1:0];
               k_in      = k_ff + ICW'(1);
               kpos_in   = kpos_ff + {1'b0, eff_stride};
               pend_in   = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               seg_in   = have_ff ? chosen_pos_ff : '0;
               i_in     = have_ff ? chosen_pos_ff : '0;
               end_in   = (have_ff && next_entry_used) ? next_entry_pos[LEN_W-1:0] : eff_len;
               pend_in  = 1'b0;
               state_in = S_SEG;
            end
         end
         S_SEG: begin
            if (pend_ff && (elem_rdata_ff == key_ff)) begin
               res_found_in = 1'b1;
               res_pos_in   = rd_pos_ff;
               state_in     = S_DONE;
            end else if (pend_ff && (elem_rdata_ff > key_ff)) begin
               state_in = S_DONE;
            end else if (i_ff < end_ff) begin
               elem_re    = 1'b1;
               elem_raddr = i_ff[AW-1:0];
               rd_pos_in  = i_ff;
               i_in       = i_ff + LEN_W'(1);
               pend_in    = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      cnt_ff        <= cnt_in;
      lt_ff         <= lt_in;
      k_ff          <= k_in;
      kpos_ff       <= kpos_in;
      rd_k_ff       <= rd_k_in;
      rd_pos_ff     <= rd_pos_in;
      have_ff       <= have_in;
      chosen_k_ff   <= chosen_k_in;
      chosen_pos_ff <= chosen_pos_in;
      i_ff          <= i_in;
      end_ff        <= end_in;
      seg_ff        <= seg_in;
      res_found_ff  <= res_found_in;
      res_oor_ff    <= res_oor_in;
      res_pos_ff    <= res_pos_in;
      if (rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_oor_ff   <= res_oor_ff;
         rsp_pos_ff   <= res_pos_ff;
         rsp_seg_ff   <= seg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem_ff[pop_addr] <= pop_value;
      end
      if (elem_re) begin
         elem_rdata_ff <= elem_mem_ff[elem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (idx_we) begin
         idx_mem_ff[pop_slot[IW-1:0]] <= pop_value;
      end
      if (idx_re) begin
         idx_rdata_ff <= idx_mem_ff[idx_raddr];
      end
   end

   assign pos_wide          = {{POS_W{1'b0}}, rsp_pos_ff};
   assign seg_wide          = {{POS_W{1'b0}}, rsp_seg_ff};
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_out_of_range  = rsp_oor_ff;
   assign rsp_position      = pos_wide[POS_W-1:0];
   assign rsp_segment_start = seg_wide[POS_W-1:0];

`ifndef SYNTH
   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEG) |-> (i_ff <= end_ff))
      else $error("segment scan ran past its end");

   a_found_vs_oor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_found_ff && rsp_oor_ff))
      else $error("response both found and out of range");

   a_pos_in_seg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_pos_ff >= rsp_seg_ff))
      else $error("match position before segment start");

   a_write_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && pop_valid && pop_ctrl.op == OP_WRITE) |=> (state_ff == S_IDLE))
      else $error("write request left the idle state");
`endif

endmodule

>>> hw/rtl/indexed_sequential_search.sv
`timescale 1ns / 1ps
// Indexed sequential search top level: configuration registers, front end,
// request queue and search engine. Uses iss_pkg, iss_front, iss_queue, iss_back.
// A load request (command 0) writes the next array element; every
// index_stride-th element, from the first, also lands in the index table
// while it has room. A search request (command 1) runs in the search engine:
// a range check reads the first and last element, the index walk reads the
// usable index entries, and the segment scan reads segment elements up to a
// match, a larger element or the segment end. A key out of range ends after
// the range check, and a zero length skips the reads. Each memory has a single
// read port, one read per cycle. A two-entry queue lets the front end keep
// taking requests while a search runs, and a result register holds the
// response until it is taken.
// Configuration writes are always ready and must only be issued while no
// request is in flight.
module indexed_sequential_search import iss_pkg::*; #(
   parameter int ARRAY_DEPTH = DEF_ARRAY_DEPTH,
   parameter int INDEX_DEPTH = DEF_INDEX_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_command,
   input  logic signed [VALUE_W-1:0] req_item_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic                      rsp_out_of_range,
   output logic [POS_W-1:0]          rsp_position,
   output logic [POS_W-1:0]          rsp_segment_start,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LEN_W = $clog2(ARRAY_DEPTH + 1);
   localparam int AW    = $clog2(ARRAY_DEPTH);
   localparam int ICW   = $clog2(INDEX_DEPTH + 1);
   localparam int CMP_W = (LEN_W > CSR_DATA_W) ? LEN_W : CSR_DATA_W;
   localparam int QW    = $bits(entry_ctrl_type) + AW + ICW + VALUE_W;

   logic [CSR_DATA_W-1:0] used_length_ff, used_length_in;
   logic [CSR_DATA_W-1:0] index_stride_ff, index_stride_in;
   logic [CMP_W-1:0]      len_wide, stride_wide, depth_wide;
   logic [CMP_W-1:0]      len_clip, stride_clip;
   logic [LEN_W-1:0]      eff_len, eff_stride;

   logic                  push_valid, push_ready, pop_valid, pop_ready;
   entry_ctrl_type        push_ctrl, pop_ctrl;
   logic [AW-1:0]         push_addr, pop_addr;
   logic [ICW-1:0]        push_slot, pop_slot;
   logic [VALUE_W-1:0]    push_value, pop_value;
   logic [QW-1:0]         push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      used_length_in  = used_length_ff;
      index_stride_in = index_stride_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_USED_LENGTH:  used_length_in  = csr_wdata;
            CSR_INDEX_STRIDE: index_stride_in = csr_wdata;
            default: begin
               used_length_in  = used_length_ff;
               index_stride_in = index_stride_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_length_ff  <= RESET_USED_LENGTH;
         index_stride_ff <= RESET_INDEX_STRIDE;
      end else begin
         used_length_ff  <= used_length_in;
         index_stride_ff <= index_stride_in;
      end
   end

   assign depth_wide  = CMP_W'(ARRAY_DEPTH);
   assign len_wide    = CMP_W'(used_length_ff);
   assign stride_wide = CMP_W'(index_stride_ff);
   assign len_clip    = (len_wide > depth_wide) ? depth_wide : len_wide;
   assign stride_clip = (stride_wide == '0) ? CMP_W'(1) :
                        ((stride_wide > depth_wide) ? depth_wide : stride_wide);
   assign eff_len     = len_clip[LEN_W-1:0];
   assign eff_stride  = stride_clip[LEN_W-1:0];

   iss_front #(
      .ARRAY_DEPTH (ARRAY_DEPTH),
      .INDEX_DEPTH (INDEX_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_item_value (req_item_value),
      .eff_len        (eff_len),
      .eff_stride     (eff_stride),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_ctrl      (push_ctrl),
      .push_addr      (push_addr),
      .push_slot      (push_slot),
      .push_value     (push_value)
   );

   assign push_data = {push_ctrl, push_addr, push_slot, push_value};

   iss_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_ctrl, pop_addr, pop_slot, pop_value} = pop_data;

   iss_back #(
      .ARRAY_DEPTH (ARRAY_DEPTH),
      .INDEX_DEPTH (INDEX_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .eff_len           (eff_len),
      .eff_stride        (eff_stride),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_ctrl          (pop_ctrl),
      .pop_addr          (pop_addr),
      .pop_slot          (pop_slot),
      .pop_value         (pop_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_out_of_range  (rsp_out_of_range),
      .rsp_position      (rsp_position),
      .rsp_segment_start (rsp_segment_start)
   );

endmodule

>>> test/tb_indexed_sequential_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_sequential_search: directed table, then random
// load/search traffic checked against an in-bench predictor. Depends on iss_pkg and the RTL.
module tb_indexed_sequential_search;
   import iss_pkg::*;

   localparam int ARRAY_SLOTS   = DEF_ARRAY_DEPTH;
   localparam int INDEX_SLOTS   = DEF_INDEX_DEPTH;
   localparam int SETTLE_CYCLES = 32;
   localparam int HOLD_CYCLES   = 400;
   localparam int LIMIT_CYCLES  = 10000000;
   localparam int PRINT_CAP     = 100;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic             found;
      logic             out_of_range;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] segment_start;
   } answer_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      csr_sel;
      logic                      command;
      logic signed [VALUE_W-1:0] value;
      bit                        typed;
      answer_type                answer;
   } stim_row_type;

   localparam answer_type ANS_NONE = '0;
   localparam answer_type ANS_OOR  = '{1'b0, 1'b1, 10'd0, 10'd0};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_command = CMD_LOAD;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_found;
   logic                      rsp_out_of_range;
   logic [POS_W-1:0]          rsp_position;
   logic [POS_W-1:0]          rsp_segment_start;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   indexed_sequential_search u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_out_of_range  (rsp_out_of_range),
      .rsp_position      (rsp_position),
      .rsp_segment_start (rsp_segment_start),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // predictor state
   logic signed [VALUE_W-1:0] elem_mem [ARRAY_SLOTS];
   logic signed [VALUE_W-1:0] idx_mem [INDEX_SLOTS];
   int unsigned               wr_ptr = 0;
   int unsigned               stride_cnt = 0;
   int unsigned               idx_cnt = 0;
   bit                        after_search = 1'b0;
   int unsigned               filled_high = 0;
   logic [CSR_DATA_W-1:0]     cfg_len = RESET_USED_LENGTH;
   logic [CSR_DATA_W-1:0]     cfg_stride = RESET_INDEX_STRIDE;

   answer_type                awaited_answers [$];
   logic signed [VALUE_W-1:0] array_vals [$];
   stim_row_type              directed_rows [26];
   int                        live_items = 0;
   int                        error_count = 0;
   int                        cycle_count = 0;
   int                        idle_pct = 0;
   int                        rsp_stall_pct = 0;
   logic                      hold_arm = 1'b0;
   logic                      rsp_hold = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("indexed_sequential_search regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // long receiver hold-off so the request queue backs up
   initial begin
      wait (hold_arm);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic int unsigned eff_len();
      return (cfg_len > ARRAY_SLOTS) ? ARRAY_SLOTS : cfg_len;
   endfunction

   function automatic int unsigned eff_stride();
      if (cfg_stride == 0) return 1;
      return (cfg_stride > ARRAY_SLOTS) ? ARRAY_SLOTS : cfg_stride;
   endfunction

   function automatic answer_type ans_hit(int p, int sg);
      return '{1'b1, 1'b0, POS_W'(p), POS_W'(sg)};
   endfunction

   function automatic answer_type ans_miss(int sg);
      return '{1'b0, 1'b0, 10'd0, POS_W'(sg)};
   endfunction

   function automatic bit store_element(logic signed [VALUE_W-1:0] v);
      if (after_search) begin
         wr_ptr = 0;
         stride_cnt = 0;
         idx_cnt = 0;
         after_search = 1'b0;
      end
      if (wr_ptr >= eff_len()) return 1'b0;
      elem_mem[wr_ptr] = v;
      if (stride_cnt == 0 && idx_cnt < INDEX_SLOTS) begin
         idx_mem[idx_cnt] = v;
         idx_cnt++;
      end
      stride_cnt = (stride_cnt + 1 >= eff_stride()) ? 0 : stride_cnt + 1;
      wr_ptr++;
      if (wr_ptr > filled_high) filled_high = wr_ptr;
      return 1'b1;
   endfunction

   function automatic answer_type index_search(logic signed [VALUE_W-1:0] key);
      answer_type  ans;
      int unsigned n, s, k, i, usable, chosen, seg, stop;
      bit          have;
      ans = '0;
      n = eff_len();
      s = eff_stride();
      usable = 0;
      chosen = 0;
      have = 1'b0;
      seg = 0;
      if (n == 0 || key < elem_mem[0] || key > elem_mem[n - 1]) begin
         ans.out_of_range = 1'b1;
         return ans;
      end
      stop = n;
      for (k = 0; k < idx_cnt && k < INDEX_SLOTS; k++) begin
         if (k * s >= n) break;
         usable = k + 1;
         if (idx_mem[k] <= key) begin
            chosen = k;
            have = 1'b1;
         end
      end
      if (have) begin
         seg = chosen * s;
         if (chosen + 1 < usable) stop = (chosen + 1) * s;
      end
      ans.segment_start = POS_W'(seg);
      for (i = seg; i < stop && elem_mem[i] <= key; i++) begin
         if (elem_mem[i] == key) begin
            ans.found = 1'b1;
            ans.position = POS_W'(i);
            break;
         end
      end
      return ans;
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   always @(posedge clock) begin : check_answers
      answer_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            report_mismatch("response with no search pending");
         end else begin
            due = awaited_answers.pop_front();
            if (rsp_found !== due.found)
               report_mismatch($sformatf("found %b, want %b", rsp_found, due.found));
            if (rsp_out_of_range !== due.out_of_range)
               report_mismatch($sformatf("out_of_range %b, want %b",
                                         rsp_out_of_range, due.out_of_range));
            if (rsp_position !== due.position)
               report_mismatch($sformatf("position %0d, want %0d", rsp_position, due.position));
            if (rsp_segment_start !== due.segment_start)
               report_mismatch($sformatf("segment_start %0d, want %0d",
                                         rsp_segment_start, due.segment_start));
         end
      end
   end

   task automatic send_request(logic cmd, logic signed [VALUE_W-1:0] val,
                               bit typed = 1'b0, answer_type typed_ans = '0);
      answer_type ans;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_item_value <= val;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_SEARCH) begin
         ans = index_search(val);
         after_search = 1'b1;
         awaited_answers.push_back(typed ? typed_ans : ans);
         live_items++;
      end else if (store_element(val)) begin
         live_items++;
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] sel, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (sel == CSR_USED_LENGTH) cfg_len = data;
      else cfg_stride = data;
      @(posedge clock);
   endtask

   // loads may still be draining after the last response
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_key();
      int unsigned last;
      if (array_vals.size() == 0) return $urandom_range(1) ? VALUE_MIN : $urandom;
      last = array_vals.size() - 1;
      case ($urandom_range(5)) inside
         [0:1]: return array_vals[$urandom_range(last)];
         2: return array_vals[$urandom_range(last)] + ($urandom_range(1) ? 1 : -1);
         3: return $urandom_range(1) ? array_vals[0] - 1 : array_vals[last] + 1;
         4: return $urandom_range(1) ? VALUE_MIN : VALUE_MAX;
         default: return $urandom;
      endcase
   endfunction

   task automatic load_ascending(int count);
      longint unsigned step_max, slack, pick;
      longint          cur;
      array_vals.delete();
      case ($urandom_range(2))
         0: step_max = 2;
         1: step_max = 1000;
         default: step_max = 64'h1_0000_0000 / (count + 1);
      endcase
      slack = 64'hFFFF_FFFF - count * step_max;
      pick = {$urandom, $urandom};
      cur = -64'sd2147483648 + longint'(pick % (slack + 1));
      repeat (count) begin
         array_vals.push_back(cur[31:0]);
         send_request(CMD_LOAD, cur[31:0]);
         cur += $urandom_range(step_max[31:0], 0);
      end
   endtask

   task automatic well_formed();
      int unsigned n, count;
      n = eff_len();
      count = n;
      if (n > 128 && filled_high >= n) count = $urandom_range(40, 1);
      load_ascending(count);
      if (count == n && $urandom_range(1)) begin
         repeat ($urandom_range(2, 1)) send_request(CMD_LOAD, $urandom);
      end
      repeat ($urandom_range(6, 1)) send_request(CMD_SEARCH, pick_key());
   endtask

   task automatic noisy();
      int unsigned n, k;
      n = eff_len();
      k = $urandom_range(((n < 40) ? n : 40) + 2, 0);
      array_vals.delete();
      repeat (k) begin
         array_vals.push_back($urandom);
         send_request(CMD_LOAD, array_vals[array_vals.size() - 1]);
      end
      if (n == 0 || filled_high >= n) begin
         repeat ($urandom_range(3, 0)) send_request(CMD_SEARCH, pick_key());
      end
   endtask

   task automatic run_phase(int len, int stride, int idle, int stall, int target,
                            bit squeeze = 1'b0);
      int start, saved;
      settle();
      write_csr(CSR_USED_LENGTH, CSR_DATA_W'(len));
      write_csr(CSR_INDEX_STRIDE, CSR_DATA_W'(stride));
      idle_pct = idle;
      rsp_stall_pct <= stall;
      start = live_items;
      if (squeeze) begin
         load_ascending(eff_len());
         hold_arm <= 1'b1;
         saved = idle_pct;
         idle_pct = 0;
         repeat (16) send_request(CMD_SEARCH, pick_key());
         idle_pct = saved;
      end
      while (live_items - start < target) begin
         if ($urandom_range(99) < 75) well_formed();
         else noisy();
      end
   endtask

   initial begin
      directed_rows = '{
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_LOAD,   -32'sd5,   1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, -32'sd5,   1'b1, ans_hit(0, 0)},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, -32'sd6,   1'b1, ANS_OOR},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, -32'sd4,   1'b1, ANS_OOR},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, VALUE_MIN, 1'b1, ANS_OOR},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, VALUE_MAX, 1'b1, ANS_OOR},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_LOAD,   32'sd7,    1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_LOAD,   32'sd9,    1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, 32'sd7,    1'b1, ans_hit(0, 0)},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, 32'sd9,    1'b1, ANS_OOR},
         '{ROW_CSR,     CSR_USED_LENGTH,  CMD_LOAD,   32'sd4,    1'b0, ANS_NONE},
         '{ROW_CSR,     CSR_INDEX_STRIDE, CMD_LOAD,   32'sd2,    1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_LOAD,   VALUE_MIN, 1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_LOAD,   -32'sd1,   1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_LOAD,   32'sd0,    1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_LOAD,   VALUE_MAX, 1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, VALUE_MIN, 1'b1, ans_hit(0, 0)},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, VALUE_MAX, 1'b1, ans_hit(3, 2)},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, 32'sd0,    1'b1, ans_hit(2, 2)},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, 32'sd5,    1'b1, ans_miss(2)},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, -32'sd1,   1'b1, ans_hit(1, 0)},
         '{ROW_CSR,     CSR_USED_LENGTH,  CMD_LOAD,   32'sd0,    1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, 32'sd0,    1'b1, ANS_OOR},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_LOAD,   32'sd3,    1'b0, ANS_NONE},
         '{ROW_CSR,     CSR_USED_LENGTH,  CMD_LOAD,   32'sd4,    1'b0, ANS_NONE},
         '{ROW_REQUEST, CSR_USED_LENGTH,  CMD_SEARCH, 32'sd0,    1'b1, ans_hit(2, 0)}
      };
      foreach (elem_mem[i]) elem_mem[i] = '0;
      foreach (idx_mem[i]) idx_mem[i] = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            settle();
            write_csr(directed_rows[r].csr_sel, directed_rows[r].value[CSR_DATA_W-1:0]);
         end else begin
            send_request(directed_rows[r].command, directed_rows[r].value,
                         directed_rows[r].typed, directed_rows[r].answer);
         end
      end

      // length, stride, sender idle %, receiver stall %, requests
      run_phase(7,    3,    0,  0,  12);
      run_phase(2047, 16,   0,  0,  1024);
      run_phase(16,   1,    68, 0,  16);
      run_phase(12,   1,    0,  68, 16);
      run_phase(1024, 1,    34, 34, 12);
      run_phase(10,   0,    34, 34, 12);
      run_phase(20,   2047, 68, 0,  12);
      run_phase(0,    5,    0,  68, 8);
      run_phase(1024, 1024, 0,  0,  8);
      run_phase(16,   4,    34, 34, 32, 1'b1);
      run_phase(2,    1024, 68, 68, 10);
      settle();

      if (error_count == 0) begin
         $display("indexed_sequential_search regression: pass");
      end else begin
         $display("indexed_sequential_search regression: fail");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/iss_pkg.sv
hw/rtl/iss_front.sv
hw/rtl/iss_queue.sv
hw/rtl/iss_back.sv
hw/rtl/indexed_sequential_search.sv
test/tb_indexed_sequential_search.sv
